FILE: hw/rtl/endpoint_mailbox_with_lifecycle_macros.svh
// Assertion macros shared by the mailbox endpoint RTL.
// Depends on nothing; included by the top level where it asserts.
`ifndef ENDPOINT_MAILBOX_WITH_LIFECYCLE_MACROS_SVH
`define ENDPOINT_MAILBOX_WITH_LIFECYCLE_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define EMB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define EMB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/emb_pkg.sv
// Types and codes of the mailbox endpoint.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package emb_pkg;

  // Operation codes of a request transaction.
  localparam logic [2:0] OP_ENQUEUE  = 3'd0;
  localparam logic [2:0] OP_DEQUEUE  = 3'd1;
  localparam logic [2:0] OP_ACTIVATE = 3'd2;
  localparam logic [2:0] OP_PAUSE    = 3'd3;
  localparam logic [2:0] OP_RESUME   = 3'd4;
  localparam logic [2:0] OP_DRAIN    = 3'd5;
  localparam logic [2:0] OP_DESTROY  = 3'd6;

  // Status codes of a response transaction.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_CLOSED = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_BLOCK  = 3'd3;
  localparam logic [2:0] ST_EOS    = 3'd4;
  localparam logic [2:0] ST_BADTR  = 3'd5;

  // Lifecycle codes, as held in the block and reported on a response.
  localparam logic [2:0] LC_CONSTRUCTED = 3'd0;
  localparam logic [2:0] LC_ACTIVE      = 3'd1;
  localparam logic [2:0] LC_PAUSED      = 3'd2;
  localparam logic [2:0] LC_DRAINING    = 3'd3;
  localparam logic [2:0] LC_DEAD        = 3'd4;

  // Register index of the ring length, taken from byte address bit 2.
  localparam logic REG_RING_LENGTH = 1'b0;
  localparam logic [4:0] RING_LENGTH_RESET = 5'd16;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] message_word;
    logic [11:0] payload_length;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_word;
    logic [4:0]  fill_level;
    logic [2:0]  lifecycle;
    logic [31:0] drop_count;
    logic [31:0] sent_count;
    logic [31:0] received_count;
    logic [63:0] byte_total;
  } rsp_item_t;

endpackage

FILE: hw/rtl/emb_channels.sv
// Valid/ready channel interfaces for the mailbox request and response.
// Depends on emb_pkg for the payload structs.
`timescale 1ns / 1ps

interface emb_req_if;
  logic               valid;
  logic               ready;
  emb_pkg::req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface emb_rsp_if;
  logic               valid;
  logic               ready;
  emb_pkg::rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: hw/rtl/endpoint_mailbox_with_lifecycle.sv
// Mailbox endpoint: a ring of message words in a synchronous memory,
// gated by a five-state lifecycle.
//
// The req channel carries one operation per transaction (enqueue, dequeue,
// activate, pause, resume, drain, destroy) with a message word and payload
// length. Each request gives exactly one response transaction on rsp with
// status, the dequeued word, fill level, lifecycle state and the counters
// as they stand after the operation.
// The taken request waits in the pending slot while the ring memory read of
// a dequeue completes, then moves to the output register that drives rsp.
// No new request is taken while the pending slot holds one: req.ready stays
// low until the slot moves on to the output register.
// The response sits in an output register, so the next request is taken
// while a response waits. If the receiver stalls with a response held and
// another pending, req.ready stays low until the output register frees.
// Reset clears the pointers, occupancy, counters and lifecycle (constructed)
// and sets the ring length register to 16; ring contents are not cleared.
// The user must write the ring length over APB only while idle; the block does not enforce it.
// Depends on emb_pkg, emb_channels and the assertion macro header.
`timescale 1ns / 1ps
`include "endpoint_mailbox_with_lifecycle_macros.svh"

module endpoint_mailbox_with_lifecycle #(
  parameter int RING_DEPTH = 16,
  parameter int WORD_BITS  = 64
) (
  input  logic        clk,
  input  logic        rst,
  emb_req_if.sink     req,
  emb_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int OCC_MIN = $clog2(RING_DEPTH + 1);
  localparam int CNT_W   = (OCC_MIN > 5) ? OCC_MIN : 5;

  logic [4:0]       ring_length;
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [CNT_W-1:0] occupancy, occupancy_next;
  logic [2:0]       lifecycle_state, lifecycle_state_next;
  logic [31:0]      dropped_total, dropped_total_next;
  logic [31:0]      sent_total, sent_total_next;
  logic [31:0]      received_total, received_total_next;
  logic [63:0]      bytes_total, bytes_total_next;

  logic [WORD_BITS-1:0] ring_store [RING_DEPTH];
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 mem_wr_en;
  logic                 mem_rd_en;

  logic             take;
  logic [2:0]       status_next;
  logic             deq_ok_next;
  logic [CNT_W-1:0] used_len;
  logic             pend_valid;
  logic [2:0]       pend_status;
  logic             pend_deq_ok;
  logic             out_valid;
  logic             out_load;
  emb_pkg::rsp_item_t out_item;

  // Step a pointer, wrapping to zero at the ring length in use.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] q;
    q = CNT_W'(p) + CNT_W'(1);
    return (q >= len) ? '0 : q[PTR_W-1:0];
  endfunction

  // Configuration port: one register, writes complete in the access cycle.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == emb_pkg::REG_RING_LENGTH) ? {27'd0, ring_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_length <= emb_pkg::RING_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == emb_pkg::REG_RING_LENGTH) begin
      ring_length <= pwdata[4:0];
    end
  end

  // Clamp the programmed length to one through the built depth.
  always_comb begin
    used_len = CNT_W'(ring_length);
    if (ring_length == 5'd0) begin
      used_len = CNT_W'(1);
    end
    if (used_len > CNT_W'(RING_DEPTH)) begin
      used_len = CNT_W'(RING_DEPTH);
    end
  end

  assign take      = req.valid && req.ready;
  assign req.ready = !pend_valid;

  // Operation decode against the current state; memory accesses issue here.
  always_comb begin
    write_pointer_next   = write_pointer;
    read_pointer_next    = read_pointer;
    occupancy_next       = occupancy;
    lifecycle_state_next = lifecycle_state;
    dropped_total_next   = dropped_total;
    sent_total_next      = sent_total;
    received_total_next  = received_total;
    bytes_total_next     = bytes_total;
    status_next          = emb_pkg::ST_OK;
    deq_ok_next          = 1'b0;
    mem_wr_en            = 1'b0;
    mem_rd_en            = 1'b0;
    if (take) begin
      case (req.item.operation)
        emb_pkg::OP_ENQUEUE: begin
          if (!(lifecycle_state inside {emb_pkg::LC_ACTIVE, emb_pkg::LC_DRAINING})) begin
            status_next = emb_pkg::ST_CLOSED;
          end else if (occupancy >= used_len) begin
            dropped_total_next = dropped_total + 32'd1;
            status_next        = emb_pkg::ST_FULL;
          end else begin
            mem_wr_en          = 1'b1;
            write_pointer_next = advance(write_pointer, used_len);
            occupancy_next     = occupancy + CNT_W'(1);
            sent_total_next    = sent_total + 32'd1;
            bytes_total_next   = bytes_total + {52'd0, req.item.payload_length};
          end
        end
        emb_pkg::OP_DEQUEUE: begin
          if (occupancy == '0) begin
            status_next = (lifecycle_state inside {emb_pkg::LC_DRAINING, emb_pkg::LC_DEAD}) ?
                          emb_pkg::ST_EOS : emb_pkg::ST_BLOCK;
          end else begin
            mem_rd_en           = 1'b1;
            deq_ok_next         = 1'b1;
            read_pointer_next   = advance(read_pointer, used_len);
            occupancy_next      = occupancy - CNT_W'(1);
            received_total_next = received_total + 32'd1;
            if (occupancy == CNT_W'(1) && lifecycle_state == emb_pkg::LC_DRAINING) begin
              lifecycle_state_next = emb_pkg::LC_DEAD;
            end
          end
        end
        emb_pkg::OP_ACTIVATE: begin
          if (lifecycle_state == emb_pkg::LC_CONSTRUCTED) begin
            lifecycle_state_next = emb_pkg::LC_ACTIVE;
          end else begin
            status_next = emb_pkg::ST_BADTR;
          end
        end
        emb_pkg::OP_PAUSE: begin
          if (lifecycle_state == emb_pkg::LC_ACTIVE) lifecycle_state_next = emb_pkg::LC_PAUSED;
          else status_next = emb_pkg::ST_BADTR;
        end
        emb_pkg::OP_RESUME: begin
          if (lifecycle_state == emb_pkg::LC_PAUSED) lifecycle_state_next = emb_pkg::LC_ACTIVE;
          else status_next = emb_pkg::ST_BADTR;
        end
        emb_pkg::OP_DRAIN: begin
          // An empty ring goes straight on to dead.
          if (lifecycle_state == emb_pkg::LC_ACTIVE) begin
            lifecycle_state_next = (occupancy == '0) ? emb_pkg::LC_DEAD : emb_pkg::LC_DRAINING;
          end else begin
            status_next = emb_pkg::ST_BADTR;
          end
        end
        emb_pkg::OP_DESTROY: begin
          lifecycle_state_next = emb_pkg::LC_DEAD;
          occupancy_next       = '0;
          write_pointer_next   = '0;
          read_pointer_next    = '0;
        end
        default: begin
          status_next = emb_pkg::ST_BADTR;
        end
      endcase
    end
  end

  // Control and counter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer   <= '0;
      read_pointer    <= '0;
      occupancy       <= '0;
      lifecycle_state <= emb_pkg::LC_CONSTRUCTED;
      dropped_total   <= '0;
      sent_total      <= '0;
      received_total  <= '0;
      bytes_total     <= '0;
    end else begin
      write_pointer   <= write_pointer_next;
      read_pointer    <= read_pointer_next;
      occupancy       <= occupancy_next;
      lifecycle_state <= lifecycle_state_next;
      dropped_total   <= dropped_total_next;
      sent_total      <= sent_total_next;
      received_total  <= received_total_next;
      bytes_total     <= bytes_total_next;
    end
  end

  // Ring memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      ring_store[write_pointer] <= req.item.message_word[WORD_BITS-1:0];
    end
    if (mem_rd_en) begin
      mem_rdata <= ring_store[read_pointer];
    end
  end

  // Pending slot waits for the memory read, then moves to the output register.
  assign out_load = pend_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) pend_valid <= 1'b1;
      else if (out_load) pend_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_status <= status_next;
      pend_deq_ok <= deq_ok_next;
    end
  end

  // The state registers already hold the post-operation values here.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.status         <= pend_status;
      out_item.read_word      <= pend_deq_ok ? 64'(mem_rdata) : 64'd0;
      out_item.fill_level     <= occupancy[4:0];
      out_item.lifecycle      <= lifecycle_state;
      out_item.drop_count     <= dropped_total;
      out_item.sent_count     <= sent_total;
      out_item.received_count <= received_total;
      out_item.byte_total     <= bytes_total;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.item  = out_item;

  // Checks on occupancy, the pending slot and the terminal lifecycle state.
  `EMB_ASSERT_NOW(a_occ_bound, clk, rst, 1'b1, occupancy <= CNT_W'(RING_DEPTH),
                  "occupancy above depth")
  `EMB_ASSERT_NEXT(a_take_pends, clk, rst, take, pend_valid, "taken request not pending")
  `EMB_ASSERT_NEXT(a_dead_stays, clk, rst, lifecycle_state == emb_pkg::LC_DEAD,
                   lifecycle_state == emb_pkg::LC_DEAD, "left dead state")
  `EMB_ASSERT_NEXT(a_pend_moves, clk, rst, out_load, out_valid, "pending response lost")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the mailbox endpoint with lifecycle.
// Depends on emb_pkg, the emb_req_if / emb_rsp_if channel interfaces and the
// endpoint_mailbox_with_lifecycle top level; needs no files or arguments.
`timescale 1ns / 1ps

module testbench;

  // The one operation code that the block does not define.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned PRINT_LIMIT = 40;

  // Shadow copy of the endpoint: works out the response to every accepted
  // request and keeps the responses still owed by the block.
  class endpoint_shadow;
    logic [63:0] slots [SLOT_COUNT];
    logic [3:0]  wr_ptr;
    logic [3:0]  rd_ptr;
    logic [4:0]  fill;
    logic [2:0]  state;
    logic [31:0] drops;
    logic [31:0] sent;
    logic [31:0] taken;
    logic [63:0] bytes;
    logic [4:0]  ring_len;
    emb_pkg::rsp_item_t owed [$];
    int unsigned failures;
    int unsigned requests;
    int unsigned responses;
    int unsigned length_writes;
    int unsigned status_tally [8];

    function new();
      foreach (slots[i]) slots[i] = '0;
      foreach (status_tally[i]) status_tally[i] = 0;
      wr_ptr = '0;
      rd_ptr = '0;
      fill = '0;
      state = emb_pkg::LC_CONSTRUCTED;
      drops = '0;
      sent = '0;
      taken = '0;
      bytes = '0;
      ring_len = emb_pkg::RING_LENGTH_RESET;
      failures = 0;
      requests = 0;
      responses = 0;
      length_writes = 0;
    endfunction

    function void set_ring_length(logic [4:0] value);
      ring_len = value;
      length_writes++;
    endfunction

    // Slots in use: zero counts as one, anything above the depth as the depth.
    function logic [4:0] span();
      if (ring_len == 5'd0) return 5'd1;
      if (ring_len > 5'(SLOT_COUNT)) return 5'(SLOT_COUNT);
      return ring_len;
    endfunction

    function logic [3:0] step(logic [3:0] ptr);
      logic [4:0] nxt;
      nxt = {1'b0, ptr} + 5'd1;
      return (nxt >= span()) ? 4'd0 : nxt[3:0];
    endfunction

    function logic [2:0] move_state(logic [2:0] from, logic [2:0] to);
      if (state != from) return emb_pkg::ST_BADTR;
      state = to;
      return emb_pkg::ST_OK;
    endfunction

    // Note an accepted request transaction and queue the response it owes.
    function void note_request(emb_pkg::req_item_t it);
      emb_pkg::rsp_item_t want;
      want = '0;
      want.status = emb_pkg::ST_OK;
      requests++;
      case (it.operation)
        emb_pkg::OP_ENQUEUE: begin
          if (state != emb_pkg::LC_ACTIVE && state != emb_pkg::LC_DRAINING) begin
            want.status = emb_pkg::ST_CLOSED;
          end else if (fill >= span()) begin
            drops++;
            want.status = emb_pkg::ST_FULL;
          end else begin
            slots[wr_ptr] = it.message_word;
            wr_ptr = step(wr_ptr);
            fill++;
            sent++;
            bytes += {52'd0, it.payload_length};
          end
        end
        emb_pkg::OP_DEQUEUE: begin
          if (fill == 5'd0) begin
            want.status = (state == emb_pkg::LC_DRAINING || state == emb_pkg::LC_DEAD) ?
                          emb_pkg::ST_EOS : emb_pkg::ST_BLOCK;
          end else begin
            want.read_word = slots[rd_ptr];
            rd_ptr = step(rd_ptr);
            fill--;
            taken++;
            if (fill == 5'd0 && state == emb_pkg::LC_DRAINING) state = emb_pkg::LC_DEAD;
          end
        end
        emb_pkg::OP_ACTIVATE:
          want.status = move_state(emb_pkg::LC_CONSTRUCTED, emb_pkg::LC_ACTIVE);
        emb_pkg::OP_PAUSE:
          want.status = move_state(emb_pkg::LC_ACTIVE, emb_pkg::LC_PAUSED);
        emb_pkg::OP_RESUME:
          want.status = move_state(emb_pkg::LC_PAUSED, emb_pkg::LC_ACTIVE);
        emb_pkg::OP_DRAIN: begin
          want.status = move_state(emb_pkg::LC_ACTIVE, emb_pkg::LC_DRAINING);
          if (want.status == emb_pkg::ST_OK && fill == 5'd0) state = emb_pkg::LC_DEAD;
        end
        emb_pkg::OP_DESTROY: begin
          state = emb_pkg::LC_DEAD;
          fill = '0;
          wr_ptr = '0;
          rd_ptr = '0;
        end
        default: want.status = emb_pkg::ST_BADTR;
      endcase
      want.fill_level = fill;
      want.lifecycle = state;
      want.drop_count = drops;
      want.sent_count = sent;
      want.received_count = taken;
      want.byte_total = bytes;
      status_tally[want.status]++;
      owed.push_back(want);
    endfunction

    task report_mismatch(string what);
      if (failures < PRINT_LIMIT)
        $display("MISMATCH at %0t, response %0d: %s", $time, responses, what);
      failures++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Check one accepted response transaction against the oldest one owed.
    task check_response(emb_pkg::rsp_item_t got);
      emb_pkg::rsp_item_t want;
      responses++;
      if (owed.size() == 0) begin
        report_mismatch("response arrived with none outstanding");
        return;
      end
      want = owed.pop_front();
      compare_field("status", 64'(got.status), 64'(want.status));
      compare_field("read_word", got.read_word, want.read_word);
      compare_field("fill_level", 64'(got.fill_level), 64'(want.fill_level));
      compare_field("lifecycle", 64'(got.lifecycle), 64'(want.lifecycle));
      compare_field("drop_count", 64'(got.drop_count), 64'(want.drop_count));
      compare_field("sent_count", 64'(got.sent_count), 64'(want.sent_count));
      compare_field("received_count", 64'(got.received_count), 64'(want.received_count));
      compare_field("byte_total", got.byte_total, want.byte_total);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  emb_req_if req_ch ();
  emb_rsp_if rsp_ch ();

  endpoint_shadow shadow = new();

  // Flags shared between the request and response processes.
  bit source_steady = 1'b0;
  bit sink_steady = 1'b0;
  bit long_hold_due = 1'b0;
  int unsigned long_holds = 0;

  endpoint_mailbox_with_lifecycle uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic emb_pkg::req_item_t make_request(logic [2:0] op, logic [63:0] word,
                                                      logic [11:0] plen);
    emb_pkg::req_item_t it;
    it.operation = op;
    it.message_word = word;
    it.payload_length = plen;
    return it;
  endfunction

  // Random request; drain only where it cannot end the lifecycle, destroy
  // only once the endpoint is already dead.
  function automatic emb_pkg::req_item_t random_request(int unsigned enqueue_share);
    emb_pkg::req_item_t it;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    it.message_word = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       it.payload_length = '0;
      1:       it.payload_length = '1;
      default: it.payload_length = 12'($urandom_range(0, 4095));
    endcase
    if (pick < enqueue_share) it.operation = emb_pkg::OP_ENQUEUE;
    else if (pick < 88) it.operation = emb_pkg::OP_DEQUEUE;
    else if (pick < 91) it.operation = emb_pkg::OP_PAUSE;
    else if (pick < 97) it.operation = emb_pkg::OP_RESUME;
    else if (pick < 98) it.operation = emb_pkg::OP_ACTIVATE;
    else if (pick < 99)
      it.operation = (shadow.state == emb_pkg::LC_ACTIVE) ? OP_UNUSED : emb_pkg::OP_DRAIN;
    else
      it.operation = (shadow.state == emb_pkg::LC_DEAD) ? emb_pkg::OP_DESTROY : OP_UNUSED;
    return it;
  endfunction

  // Offer one request transaction; entered and left at a falling edge.
  task automatic send_request(input emb_pkg::req_item_t it);
    int unsigned gap;
    gap = source_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.item <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    shadow.note_request(it);
    @(negedge clk);
  endtask

  // Stop offering and wait until every owed response has been taken.
  task automatic wait_until_settled();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (shadow.owed.size() != 0);
  endtask

  // APB write of the ring length: setup cycle, then access cycle.
  task automatic write_ring_length(input logic [4:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {emb_pkg::REG_RING_LENGTH, 2'b00};
    pwdata <= {27'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow.set_ring_length(value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Response side: random stalls, steady stretches and the odd long hold.
  initial begin : response_sink
    int unsigned pause_len;
    rsp_ch.ready <= 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        pause_len = LONG_HOLD_CYCLES;
        long_holds++;
      end else begin
        pause_len = sink_steady ? 0 : $urandom_range(0, 15);
      end
      if (pause_len > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (pause_len) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      shadow.check_response(rsp_ch.item);
      if ($urandom_range(0, 63) == 0) sink_steady = !sink_steady;
      @(negedge clk);
    end
  end

  // Request side: directed opening, random phases, then the end of life.
  initial begin : request_source
    logic [4:0]  lengths [8];
    int unsigned phase;
    int unsigned n;
    int unsigned enqueue_share;
    int unsigned ending;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.item <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_ring_length(5'd16);

    // Before activation nothing may be queued and pause is refused; a second activate is refused too.
    send_request(make_request(emb_pkg::OP_ENQUEUE, '1, '1));
    send_request(make_request(emb_pkg::OP_DEQUEUE, '0, '0));
    send_request(make_request(emb_pkg::OP_PAUSE, '0, '0));
    send_request(make_request(OP_UNUSED, '1, '1));
    send_request(make_request(emb_pkg::OP_ACTIVATE, '0, '0));
    send_request(make_request(emb_pkg::OP_ACTIVATE, '0, '0));

    // Fill every slot once with extreme words, then overflow by one.
    for (n = 0; n < SLOT_COUNT; n++) begin
      case (n)
        0:       send_request(make_request(emb_pkg::OP_ENQUEUE, '0, '0));
        1:       send_request(make_request(emb_pkg::OP_ENQUEUE, '1, '1));
        2:       send_request(make_request(emb_pkg::OP_ENQUEUE, {16{4'hA}}, 12'hAAA));
        3:       send_request(make_request(emb_pkg::OP_ENQUEUE, {16{4'h5}}, 12'h555));
        default: send_request(make_request(emb_pkg::OP_ENQUEUE, {$urandom, $urandom},
                                           12'($urandom_range(0, 4095))));
      endcase
    end
    send_request(make_request(emb_pkg::OP_ENQUEUE, {$urandom, $urandom}, '1));

    // Paused: enqueue is closed, drain is refused, dequeue still works.
    send_request(make_request(emb_pkg::OP_PAUSE, '0, '0));
    send_request(make_request(emb_pkg::OP_ENQUEUE, '1, '1));
    send_request(make_request(emb_pkg::OP_DRAIN, '0, '0));
    send_request(make_request(emb_pkg::OP_DEQUEUE, '1, '1));
    send_request(make_request(emb_pkg::OP_RESUME, '0, '0));

    // Random phases, each under its own ring length, changed with data held.
    lengths = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd16, 5'd8, 5'd16};
    lengths[5] = 5'($urandom_range(3, 15));
    for (phase = 0; phase < 8; phase++) begin
      wait_until_settled();
      write_ring_length(lengths[phase]);
      source_steady = (phase == 2 || phase == 5);
      enqueue_share = $urandom_range(25, 65);
      for (n = 0; n < 150; n++) begin
        if (n == 10 && (phase == 1 || phase == 4)) long_hold_due = 1'b1;
        if (n == 75 && phase == 3) wait_until_settled();
        send_request(random_request(enqueue_share));
      end
    end

    // End of life: one of three routes into the dead state.
    wait_until_settled();
    source_steady = 1'b0;
    if (shadow.state == emb_pkg::LC_PAUSED)
      send_request(make_request(emb_pkg::OP_RESUME, '0, '0));
    repeat (4) send_request(make_request(emb_pkg::OP_ENQUEUE, {$urandom, $urandom},
                                         12'($urandom_range(0, 4095))));
    ending = $urandom_range(0, 2);
    case (ending)
      0: begin
        // Drain with data, keep enqueuing while draining, empty it out.
        send_request(make_request(emb_pkg::OP_DRAIN, '0, '0));
        repeat (2) send_request(make_request(emb_pkg::OP_ENQUEUE, {$urandom, $urandom}, '1));
        while (shadow.fill != 5'd0) send_request(make_request(emb_pkg::OP_DEQUEUE, '0, '0));
        send_request(make_request(emb_pkg::OP_DEQUEUE, '0, '0));
        send_request(make_request(emb_pkg::OP_DESTROY, '0, '0));
      end
      1: begin
        // Empty ring first, so that drain goes straight to dead.
        while (shadow.fill != 5'd0) send_request(make_request(emb_pkg::OP_DEQUEUE, '0, '0));
        send_request(make_request(emb_pkg::OP_DEQUEUE, '0, '0));
        send_request(make_request(emb_pkg::OP_DRAIN, '0, '0));
        send_request(make_request(emb_pkg::OP_DEQUEUE, '0, '0));
        send_request(make_request(emb_pkg::OP_DESTROY, '0, '0));
      end
      default: begin
        // Destroy while messages are still held.
        send_request(make_request(emb_pkg::OP_DRAIN, '0, '0));
        send_request(make_request(emb_pkg::OP_DEQUEUE, '0, '0));
        send_request(make_request(emb_pkg::OP_DESTROY, '0, '0));
        send_request(make_request(emb_pkg::OP_DEQUEUE, '0, '0));
      end
    endcase
    send_request(make_request(emb_pkg::OP_ENQUEUE, '1, '1));
    send_request(make_request(emb_pkg::OP_ACTIVATE, '0, '0));
    send_request(make_request(emb_pkg::OP_PAUSE, '0, '0));
    send_request(make_request(emb_pkg::OP_RESUME, '0, '0));
    send_request(make_request(emb_pkg::OP_DRAIN, '0, '0));
    send_request(make_request(OP_UNUSED, '0, '0));
    repeat (30) send_request(random_request(50));

    // Let any stray response show itself before the verdict.
    wait_until_settled();
    repeat (16) @(posedge clk);
    $display("Ran %0d requests under %0d ring-length settings, %0d long receiver holds.",
             shadow.requests, shadow.length_writes, long_holds);
    $display("Seen %0d full-ring drops, %0d would-block, %0d end-of-stream, %0d refused.",
             shadow.status_tally[emb_pkg::ST_FULL], shadow.status_tally[emb_pkg::ST_BLOCK],
             shadow.status_tally[emb_pkg::ST_EOS], shadow.status_tally[emb_pkg::ST_BADTR]);
    if (shadow.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin : watchdog
    #(5_000_000);
    $display("Timed out with %0d responses outstanding.", shadow.owed.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
